### rtl/yrr_pkg.sv
// Package for the YUV 4:2:0 to RGB raster converter.
// Word types, widths, register indexes and conversion constants; no dependencies.
package yrr_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 4096;
   localparam int LINE_DEPTH  = MAX_WIDTH / 2;
   localparam int SLOT_BITS   = $clog2(LINE_DEPTH);
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int WIDTH_BITS  = 12;
   localparam int HEIGHT_BITS = 13;
   localparam int CSR_BITS    = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

   localparam int PROD_BITS = 20;
   localparam logic signed [PROD_BITS-1:0] K_LUMA    = 20'sd298;
   localparam logic signed [PROD_BITS-1:0] K_RED_V   = 20'sd409;
   localparam logic signed [PROD_BITS-1:0] K_GREEN_U = 20'sd100;
   localparam logic signed [PROD_BITS-1:0] K_GREEN_V = 20'sd208;
   localparam logic signed [PROD_BITS-1:0] K_BLUE_U  = 20'sd516;
   localparam logic signed [PROD_BITS-1:0] K_ROUND   = 20'sd128;
   localparam logic [8:0] LUMA_OFFSET   = 9'd16;
   localparam logic [8:0] CHROMA_OFFSET = 9'd128;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic       frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
      logic       row_end;
      logic       frame_end;
   } pix_word_type;

endpackage

### rtl/yrr_front.sv
// Front end: raster counters, chroma line store and frame size registers.
// Emits one pixel word with its resolved chroma pair; depends on yrr_pkg.
module yrr_front
   import yrr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [CSR_BITS-1:0]   csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  pix_valid,
   input  logic                  pix_stall,
   output pix_word_type          pix_word
);

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [WIDTH_BITS-1:0]  width_in;
   logic [HEIGHT_BITS-1:0] height_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [15:0]            cur_pair_ff, cur_pair_in;
   logic [15:0]            pair_ff, pair_in;
   logic [15:0]            line_rd_ff;
   logic [15:0]            line_mem [LINE_DEPTH];
   logic                   use_line_ff;
   logic [7:0]             luma_ff;
   logic                   row_end_ff, frame_end_ff;
   logic                   valid_ff, valid_in;
   logic                   accept;
   logic                   even_even;
   logic                   last_col, last_row;
   logic [SLOT_BITS-1:0]   slot;
   logic [WIDTH_BITS-1:0]  even_width;

   assign req_stall = valid_ff && pix_stall;
   assign accept    = req_valid && !req_stall;
   assign slot      = col_ff[COL_BITS-1:1];
   assign even_even = !row_ff[0] && !col_ff[0];
   assign last_col  = ({1'b0, col_ff} + 12'd1) >= width_ff;
   assign last_row  = ({1'b0, row_ff} + 13'd1) >= height_ff;

   always_comb begin
      even_width = {csr_write_data[WIDTH_BITS-1:1], 1'b0};
      width_in   = width_ff;
      height_in  = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               if (even_width < 12'd2) begin
                  width_in = 12'd2;
               end else if (even_width > WIDTH_BITS'(MAX_WIDTH)) begin
                  width_in = WIDTH_BITS'(MAX_WIDTH);
               end else begin
                  width_in = even_width;
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_write_data == '0) begin
                  height_in = 13'd1;
               end else if (csr_write_data > HEIGHT_BITS'(MAX_HEIGHT)) begin
                  height_in = HEIGHT_BITS'(MAX_HEIGHT);
               end else begin
                  height_in = csr_write_data;
               end
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      cur_pair_in = cur_pair_ff;
      pair_in     = cur_pair_ff;
      if (even_even) begin
         pair_in = {req_word.chroma_blue, req_word.chroma_red};
      end
      if (accept) begin
         if (even_even) begin
            cur_pair_in = pair_in;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      valid_in = accept || (valid_ff && pix_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         cur_pair_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         cur_pair_ff <= cur_pair_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         luma_ff      <= req_word.luma;
         pair_ff      <= pair_in;
         use_line_ff  <= row_ff[0];
         row_end_ff   <= last_col;
         frame_end_ff <= last_col && last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && even_even) begin
         line_mem[slot] <= pair_in;
      end
      if (accept && row_ff[0]) begin
         line_rd_ff <= line_mem[slot];
      end
   end

   always_comb begin
      pix_valid          = valid_ff;
      pix_word.luma      = luma_ff;
      {pix_word.chroma_blue, pix_word.chroma_red} = use_line_ff ? line_rd_ff : pair_ff;
      pix_word.row_end   = row_end_ff;
      pix_word.frame_end = frame_end_ff;
   end

endmodule

### rtl/yrr_queue.sv
// Short queue of pixel words between the front end and the color math.
// Full flag comes straight from the count register; depends on yrr_pkg.
module yrr_queue
   import yrr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_stall,
   input  pix_word_type push_word,
   output logic         pop_valid,
   input  logic         pop_stall,
   output pix_word_type pop_word
);

   pix_word_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   head_ff, head_in;
   logic [QPTR_BITS-1:0]   tail_ff, tail_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   push, pop;

   assign push_stall = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;
   assign pop_word   = slots_ff[head_ff];

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[tail_ff] <= push_word;
      end
   end

endmodule

### rtl/yrr_back.sv
// Back end: BT.601 integer color math in two stages with clipping.
// Products are registered before the sums; depends on yrr_pkg.
module yrr_back
   import yrr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pix_valid,
   output logic         pix_stall,
   input  pix_word_type pix_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   typedef logic signed [PROD_BITS-1:0] prod_type;

   function automatic logic [7:0] clip_channel(input prod_type sum);
      logic [7:0] result;
      if (sum[PROD_BITS-1]) begin
         result = 8'd0;
      end else if (|sum[PROD_BITS-2:16]) begin
         result = 8'd255;
      end else begin
         result = sum[15:8];
      end
      return result;
   endfunction

   prod_type     c_ext, d_ext, e_ext;
   prod_type     p_luma_ff, p_red_v_ff, p_green_u_ff, p_green_v_ff, p_blue_u_ff;
   prod_type     sum_red, sum_green, sum_blue;
   logic         s1_row_end_ff, s1_frame_end_ff;
   logic         s1_valid_ff, s1_valid_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   logic         out_adv, s1_adv, take;

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign s1_adv    = !s1_valid_ff || out_adv;
   assign pix_stall = !s1_adv;
   assign take      = pix_valid && s1_adv;

   always_comb begin
      c_ext = PROD_BITS'($signed({1'b0, pix_word.luma} - LUMA_OFFSET));
      d_ext = PROD_BITS'($signed({1'b0, pix_word.chroma_blue} - CHROMA_OFFSET));
      e_ext = PROD_BITS'($signed({1'b0, pix_word.chroma_red} - CHROMA_OFFSET));
      sum_red   = p_luma_ff + p_red_v_ff + K_ROUND;
      sum_green = p_luma_ff - p_green_u_ff - p_green_v_ff + K_ROUND;
      sum_blue  = p_luma_ff + p_blue_u_ff + K_ROUND;
      s1_valid_in  = s1_adv ? pix_valid : s1_valid_ff;
      out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         p_luma_ff       <= c_ext * K_LUMA;
         p_red_v_ff      <= e_ext * K_RED_V;
         p_green_u_ff    <= d_ext * K_GREEN_U;
         p_green_v_ff    <= e_ext * K_GREEN_V;
         p_blue_u_ff     <= d_ext * K_BLUE_U;
         s1_row_end_ff   <= pix_word.row_end;
         s1_frame_end_ff <= pix_word.frame_end;
      end
      if (out_adv && s1_valid_ff) begin
         out_word_ff.red       <= clip_channel(sum_red);
         out_word_ff.green     <= clip_channel(sum_green);
         out_word_ff.blue      <= clip_channel(sum_blue);
         out_word_ff.row_end   <= s1_row_end_ff;
         out_word_ff.frame_end <= s1_frame_end_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

### rtl/yuv420_to_rgb_raster.sv
// Top level of the YUV 4:2:0 to RGB888 raster converter.
// Instantiates yrr_front, yrr_queue and yrr_back; depends on yrr_pkg.
//
//   channel   direction  handshake          word
//   req       in         req_valid/stall    luma, chroma_blue, chroma_red
//   rsp       out        rsp_valid/stall    red, green, blue, row_end, frame_end
//   csr       in         csr_write_enable   csr_index, csr_write_data
//
// One pixel is accepted per clock while req_stall is low; rsp_valid rises once the pixel has
// passed the front-end register, the queue and the s1 and out registers of the back end.
// Reset clears the counters and restores a 640 by 480 frame; the line store is not cleared.
// The queue lets the front end keep accepting while rsp is stalled, until it fills.
module yuv420_to_rgb_raster
   import yrr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [CSR_BITS-1:0] csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_word_type        req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_word_type        rsp_word
);

   logic         front_valid, front_stall;
   pix_word_type front_word;
   logic         back_valid, back_stall;
   pix_word_type back_word;

   yrr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .pix_valid        (front_valid),
      .pix_stall        (front_stall),
      .pix_word         (front_word)
   );

   yrr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_stall (front_stall),
      .push_word  (front_word),
      .pop_valid  (back_valid),
      .pop_stall  (back_stall),
      .pop_word   (back_word)
   );

   yrr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (back_valid),
      .pix_stall (back_stall),
      .pix_word  (back_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for yuv420_to_rgb_raster: drives pixel words, predicts each RGB word and checks it.
// Depends on yrr_pkg and the RTL of the converter; needs no files or arguments.
module tb_top;
   import yrr_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic                csr_index = CSR_FRAME_WIDTH;
   logic [CSR_BITS-1:0] csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_word_type        req_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_word_type        rsp_word;

   logic [WIDTH_BITS-1:0]  width_reg = WIDTH_RESET;
   logic [HEIGHT_BITS-1:0] height_reg = HEIGHT_RESET;
   int unsigned            col_pos = 0;
   int unsigned            row_pos = 0;
   logic [15:0]            held_pair = '0;
   logic [15:0]            chroma_store [LINE_DEPTH];
   logic                   line_written [LINE_DEPTH] = '{default: 1'b0};

   rsp_word_type expected_pixels [$];
   int unsigned  pixels_sent = 0;
   int unsigned  failures = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  idle_pct = 8;

   yuv420_to_rgb_raster dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic int unsigned used_width();
      int unsigned w;
      w = 32'(width_reg & 12'hFFE);
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned used_height();
      int unsigned h;
      h = 32'(height_reg);
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   function automatic logic [7:0] clamp_channel(int sum);
      if (sum < 0) return 8'd0;
      sum = sum >>> 8;
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   // Advances the raster position and returns the RGB word for one pixel.
   function automatic rsp_word_type convert_pixel(req_word_type pix);
      rsp_word_type res;
      int unsigned  w, h, slot;
      logic [15:0]  pair;
      int           c, d, e;
      logic         last_col, last_row;
      w = used_width();
      h = used_height();
      slot = (col_pos >> 1) % LINE_DEPTH;
      if (row_pos % 2 == 0) begin
         if (col_pos % 2 == 0) begin
            held_pair = {pix.chroma_blue, pix.chroma_red};
            chroma_store[slot] = held_pair;
            line_written[slot] = 1'b1;
         end
         pair = held_pair;
      end else begin
         pair = chroma_store[slot];
      end
      c = int'(pix.luma);
      c = c - 16;
      d = int'(pair[15:8]);
      d = d - 128;
      e = int'(pair[7:0]);
      e = e - 128;
      res.red   = clamp_channel(298 * c + 409 * e + 128);
      res.green = clamp_channel(298 * c - 100 * d - 208 * e + 128);
      res.blue  = clamp_channel(298 * c + 516 * d + 128);
      last_col = (col_pos + 1 >= w);
      last_row = (row_pos + 1 >= h);
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return res;
   endfunction

   // On an odd row, the pixel after this one must find its line-store entry written.
   function automatic logic next_read_defined();
      int unsigned nxt;
      if (row_pos % 2 == 0 || col_pos + 1 >= used_width()) return 1'b1;
      nxt = col_pos + 1;
      return line_written[(nxt >> 1) % LINE_DEPTH];
   endfunction

   function automatic req_word_type random_pixel();
      req_word_type pix;
      pix = 24'($urandom);
      return pix;
   endfunction

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("Unexpected word: r=%0d g=%0d b=%0d row_end=%0b frame_end=%0b",
                        rsp_word.red, rsp_word.green, rsp_word.blue,
                        rsp_word.row_end, rsp_word.frame_end);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_word.red !== want.red || rsp_word.green !== want.green ||
                rsp_word.blue !== want.blue || rsp_word.row_end !== want.row_end ||
                rsp_word.frame_end !== want.frame_end) begin
               failures++;
               if (failures <= 10)
                  $display("Mismatch: expected %0d,%0d,%0d,%0b,%0b got %0d,%0d,%0d,%0b,%0b",
                           want.red, want.green, want.blue, want.row_end, want.frame_end,
                           rsp_word.red, rsp_word.green, rsp_word.blue,
                           rsp_word.row_end, rsp_word.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_pixel(input req_word_type pix);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_pixels.push_back(convert_pixel(pix));
      pixels_sent++;
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) send_pixel(random_pixel());
   endtask

   task automatic finish_frame();
      while (col_pos != 0 || row_pos != 0) send_pixel(random_pixel());
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_BITS-1:0] value);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_FRAME_WIDTH)
         width_reg = value[WIDTH_BITS-1:0];
      else
         height_reg = value[HEIGHT_BITS-1:0];
   endtask

   // The first row after reset runs at the reset width and fills part of the line store.
   task automatic test_default_frame();
      send_random(640);
   endtask

   // A zero width runs as two; the widest setting then runs without any idling.
   task automatic test_width_extremes();
      write_reg(CSR_FRAME_WIDTH, 13'd0);
      send_random(2);
      write_reg(CSR_FRAME_WIDTH, 13'h0FFF);
      write_reg(CSR_FRAME_HEIGHT, 13'h1FFF);
      idle_pct = 0;
      send_random(64);
      idle_pct = 8;
   endtask

   // Shrinking the frame while the counters sit past the new limits ends the row or frame.
   task automatic test_midframe_write();
      write_reg(CSR_FRAME_WIDTH, 13'd4);
      send_random(3);
      write_reg(CSR_FRAME_HEIGHT, 13'd3);
      send_random(4);
      write_reg(CSR_FRAME_WIDTH, 13'd6);
      write_reg(CSR_FRAME_HEIGHT, 13'd2);
      finish_frame();
   endtask

   // Extreme luma and chroma values, ignored chroma, and single-row frames.
   task automatic test_field_extremes();
      write_reg(CSR_FRAME_WIDTH, 13'd4);
      write_reg(CSR_FRAME_HEIGHT, 13'd2);
      send_pixel({8'd255, 8'd255, 8'd255});
      send_pixel({8'd0, 8'd0, 8'd0});
      send_pixel({8'd16, 8'd0, 8'd0});
      send_pixel({8'd235, 8'd128, 8'd128});
      send_pixel({8'd0, 8'd77, 8'd200});
      send_pixel({8'd255, 8'd0, 8'd255});
      send_pixel({8'd128, 8'd255, 8'd0});
      send_pixel({8'd1, 8'd128, 8'd128});
      write_reg(CSR_FRAME_WIDTH, 13'd2);
      write_reg(CSR_FRAME_HEIGHT, 13'd1);
      send_pixel({8'd128, 8'd0, 8'd255});
      send_pixel({8'd128, 8'd255, 8'd0});
      send_pixel({8'd255, 8'd128, 8'd128});
      send_pixel({8'd0, 8'd255, 8'd255});
   endtask

   // Mostly whole frames of random small sizes, with broken frames and odd or
   // out-of-range sizes mixed in.
   task automatic test_random_frames();
      int unsigned         target, area, n;
      logic [CSR_BITS-1:0] value;
      target = pixels_sent + 180;
      while (pixels_sent < target) begin
         idle_pct = ($urandom_range(9) == 0) ? 0 : 8;
         if ($urandom_range(9) < 7) begin
            case ($urandom_range(19))
               0: value = CSR_BITS'($urandom_range(1));
               1: value = CSR_BITS'($urandom_range(12'hFFF, 12'h801));
               2, 3, 4: value = CSR_BITS'($urandom_range(8) * 2 + 1);
               default: value = CSR_BITS'($urandom_range(8, 1) * 2);
            endcase
            write_reg(CSR_FRAME_WIDTH, value);
         end
         if ($urandom_range(9) < 7) begin
            case ($urandom_range(9))
               0: value = 13'd0;
               1: value = CSR_BITS'($urandom_range(13'h1FFF, 13'h1000));
               default: value = CSR_BITS'($urandom_range(6, 1));
            endcase
            write_reg(CSR_FRAME_HEIGHT, value);
         end
         area = used_width() * used_height();
         if (area <= 128 && $urandom_range(4) != 0) begin
            finish_frame();
            send_random($urandom_range(3, 1) * area);
         end else begin
            n = $urandom_range(40, 1);
            while (n != 0 && next_read_defined()) begin
               send_pixel(random_pixel());
               n--;
            end
         end
      end
      idle_pct = 8;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_frame();
      test_width_extremes();
      test_midframe_write();
      test_field_extremes();
      test_random_frames();
      settle();
      failures += expected_pixels.size();
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
